// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the root finder modules.
// Each macro takes a label, the clock, the active-low reset and the checked terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/brf_pkg.sv =====
package brf_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int unsigned FRAC_BITS_DEF = 16;
  // Width of the compare between the scaled width and the relative limit.
  localparam int unsigned CMP_W = 64;
  // Reset value of both tolerance registers.
  localparam logic [30:0] TOL_RESET = 31'd66;

  typedef enum logic {
    OP_START = 1'b0,
    OP_VALUE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_EVAL  = 2'd0,
    KIND_ROOT  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_UNEXP = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2,
    PH_ITER = 2'd3
  } phase_e;

  typedef enum logic {
    CFG_ABS_TOL = 1'b0,
    CFG_REL_TOL = 1'b1
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;       // load bracket and target, request f(low)
    logic capture;     // latch the residual of the returned value
    logic unexpected;  // value arrived while idle
    logic upd_low;     // store residual of the low end, request f(high)
    logic upd_high;    // store residual of the high end
    logic set_bad;     // report a bad bracket
    logic upd_iter;    // fold the probe into the bracket
    logic prep;        // register width, product and divider operands
    logic root;        // report the final root
    logic div_step;    // one quotient bit
    logic step_mul;    // width times step fraction
    logic probe;       // form the next probe point
    logic emit;        // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad_bracket;
    logic stop;
    logic den_zero;
  } dp_sts_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

  // Magnitude of a signed 32-bit value; the most negative value fits unsigned.
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-33'(v)) : 32'(v);
  endfunction

  // True when the two values do not share a strict sign; zero counts as either.
  function automatic logic sign_change(input logic signed [31:0] a,
                                       input logic signed [31:0] b);
    return ((!a[31]) && (b[31] || (b == 32'sd0))) ||
           ((a[31] || (a == 32'sd0)) && (!b[31]));
  endfunction

endpackage

// ===== rtl/core/brf_datapath.sv =====
`include "assert_macros.svh"

module brf_datapath #(
  parameter int unsigned FRAC_BITS = brf_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  brf_pkg::dp_cmd_t     cmd_i,
  output brf_pkg::dp_sts_t     sts_o,
  input  logic signed [31:0]   bracket_low_i,
  input  logic signed [31:0]   bracket_high_i,
  input  logic signed [31:0]   target_value_i,
  input  logic signed [31:0]   function_value_i,
  output logic [1:0]           kind_o,
  output logic signed [31:0]   x_value_o
);
  import brf_pkg::*;

  localparam int unsigned MUL_W = 33 + FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] StepFloor =
    FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  logic [30:0]             abs_tol_q, rel_tol_q;
  logic signed [31:0]      low_q, high_q, res_low_q, res_high_q, probe_q, target_q;
  logic signed [31:0]      resid_q;
  logic [32:0]             dx_q;
  logic signed [CMP_W-1:0] prod_q;
  logic                    from_low_q;
  logic [32:0]             rem_q, den_q;
  logic [FRAC_BITS-1:0]    quo_q;
  logic [MUL_W-1:0]        mul_q;
  kind_e                   res_kind_q, kind_q;
  logic signed [31:0]      res_x_q, x_q;

  logic signed [34:0]      in_diff;
  logic [31:0]             mag_low, mag_high;
  logic signed [32:0]      end_sum;
  logic [29:0]             rel_half;
  logic [CMP_W-1:0]        dx_scaled;
  logic [33:0]             rem_shl;
  logic                    rem_ge;
  logic [FRAC_BITS-1:0]    frac;
  logic [32:0]             step;
  logic signed [34:0]      probe_raw;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_tol_q <= TOL_RESET;
      rel_tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_ABS_TOL) begin
        abs_tol_q <= cfg_data_i[30:0];
      end else begin
        rel_tol_q <= cfg_data_i[30:0];
      end
    end
  end

  // Shared arithmetic terms.
  assign in_diff   = 35'(function_value_i) - 35'(target_q);
  assign mag_low   = mag32(res_low_q);
  assign mag_high  = mag32(res_high_q);
  assign end_sum   = 33'(low_q) + 33'(high_q);
  assign rel_half  = rel_tol_q[30:1];
  assign dx_scaled = CMP_W'(dx_q) << FRAC_BITS;
  assign rem_shl   = {rem_q, 1'b0};
  assign rem_ge    = rem_shl >= 34'(den_q);
  assign frac      = (quo_q < StepFloor) ? StepFloor : quo_q;
  assign step      = mul_q[MUL_W-1:FRAC_BITS];
  assign probe_raw = from_low_q ? (35'(low_q) + $signed({2'b00, step}))
                                : (35'(high_q) - $signed({2'b00, step}));

  // Status toward the controller.
  assign sts_o.bad_bracket = (low_q > high_q) || !sign_change(res_low_q, resid_q);
  assign sts_o.stop        = !((dx_q > 33'(abs_tol_q)) && ($signed(dx_scaled) > prod_q));
  assign sts_o.den_zero    = (den_q == 33'd0);

  // Bracket, residual and iteration registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      low_q    <= bracket_low_i;
      high_q   <= bracket_high_i;
      target_q <= target_value_i;
    end
    if (cmd_i.capture) begin
      resid_q <= sat32(in_diff);
    end
    if (cmd_i.upd_low) begin
      res_low_q <= resid_q;
    end
    if (cmd_i.upd_high) begin
      res_high_q <= resid_q;
    end
    // Keep the sub-bracket that still shows a sign change.
    if (cmd_i.upd_iter) begin
      if (sign_change(res_low_q, resid_q)) begin
        high_q     <= probe_q;
        res_high_q <= resid_q;
      end else begin
        low_q     <= probe_q;
        res_low_q <= resid_q;
      end
    end
    // Width, relative limit and divider operands.
    if (cmd_i.prep) begin
      dx_q       <= 33'(34'(high_q) - 34'(low_q));
      prod_q     <= CMP_W'($signed({1'b0, rel_half})) * CMP_W'(end_sum);
      from_low_q <= mag_low < mag_high;
      rem_q      <= (mag_low < mag_high) ? 33'(mag_low) : 33'(mag_high);
      den_q      <= 33'(mag_low) + 33'(mag_high);
      quo_q      <= '0;
    end
    // Restoring division, one quotient bit per cycle.
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? 33'(rem_shl - 34'(den_q)) : rem_shl[32:0];
      quo_q <= {quo_q[FRAC_BITS-2:0], rem_ge};
    end
    if (cmd_i.step_mul) begin
      mul_q <= MUL_W'(dx_q) * MUL_W'(frac);
    end
    if (cmd_i.probe) begin
      probe_q <= sat32(probe_raw);
    end
  end

  // Staged result, then the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      res_kind_q <= KIND_EVAL;
      res_x_q    <= bracket_low_i;
    end else if (cmd_i.unexpected) begin
      res_kind_q <= KIND_UNEXP;
      res_x_q    <= '0;
    end else if (cmd_i.upd_low) begin
      res_kind_q <= KIND_EVAL;
      res_x_q    <= high_q;
    end else if (cmd_i.set_bad) begin
      res_kind_q <= KIND_BAD;
      res_x_q    <= '0;
    end else if (cmd_i.root) begin
      res_kind_q <= KIND_ROOT;
      res_x_q    <= from_low_q ? low_q : high_q;
    end else if (cmd_i.probe) begin
      res_kind_q <= KIND_EVAL;
      res_x_q    <= sat32(probe_raw);
    end
    if (cmd_i.emit) begin
      kind_q <= res_kind_q;
      x_q    <= res_x_q;
    end
  end

  assign kind_o    = kind_q;
  assign x_value_o = x_q;

  // The probe never leaves the bracket, and an iteration keeps a sign change.
  `ASSERT_NEXT(probe_in_bracket_a, clk_i, rst_ni, cmd_i.probe,
               (probe_q >= low_q) && (probe_q <= high_q))
  `ASSERT_NEXT(iter_keeps_sign_a, clk_i, rst_ni, cmd_i.upd_iter,
               sign_change(res_low_q, res_high_q))
  // The partial remainder stays below the divisor throughout the division.
  `ASSERT_ALWAYS(rem_below_den_a, clk_i, rst_ni, cmd_i.div_step |-> (rem_q < den_q))

endmodule

// ===== rtl/core/brf_ctrl.sv =====
`include "assert_macros.svh"

module brf_ctrl #(
  parameter int unsigned FRAC_BITS = brf_pkg::FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             opcode_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output brf_pkg::dp_cmd_t cmd_o,
  input  brf_pkg::dp_sts_t sts_i
);
  import brf_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAC_BITS);

  typedef enum logic [7:0] {
    ST_READY  = 8'b0000_0001,
    ST_UPDATE = 8'b0000_0010,
    ST_TEST   = 8'b0000_0100,
    ST_DECIDE = 8'b0000_1000,
    ST_DIV    = 8'b0001_0000,
    ST_STEP   = 8'b0010_0000,
    ST_PROBE  = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept, out_free;

  assign in_stall_o = (state_q != ST_READY);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequencer for one transaction at a time.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_READY: begin
        if (accept) begin
          if (opcode_i == OP_START) begin
            cmd_o.start = 1'b1;
            phase_d     = PH_LOW;
            state_d     = ST_EMIT;
          end else begin
            cmd_o.capture = 1'b1;
            if (phase_q == PH_IDLE) begin
              cmd_o.unexpected = 1'b1;
              state_d          = ST_EMIT;
            end else begin
              state_d = ST_UPDATE;
            end
          end
        end
      end
      ST_UPDATE: begin
        unique case (phase_q)
          PH_LOW: begin
            cmd_o.upd_low = 1'b1;
            phase_d       = PH_HIGH;
            state_d       = ST_EMIT;
          end
          PH_HIGH: begin
            cmd_o.upd_high = 1'b1;
            if (sts_i.bad_bracket) begin
              cmd_o.set_bad = 1'b1;
              phase_d       = PH_IDLE;
              state_d       = ST_EMIT;
            end else begin
              state_d = ST_TEST;
            end
          end
          PH_ITER: begin
            cmd_o.upd_iter = 1'b1;
            state_d        = ST_TEST;
          end
          PH_IDLE: begin
            state_d = ST_READY;
          end
          default: begin
            state_d = ST_READY;
          end
        endcase
      end
      ST_TEST: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DECIDE;
      end
      ST_DECIDE: begin
        cnt_d = '0;
        if (sts_i.stop) begin
          cmd_o.root = 1'b1;
          phase_d    = PH_IDLE;
          state_d    = ST_EMIT;
        end else if (sts_i.den_zero) begin
          state_d = ST_STEP;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.step_mul = 1'b1;
        state_d        = ST_PROBE;
      end
      ST_PROBE: begin
        cmd_o.probe = 1'b1;
        phase_d     = PH_ITER;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_READY;
        end
      end
      default: begin
        state_d = ST_READY;
      end
    endcase
  end

  // Output valid: set on load, cleared once the output is not stalled.
  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_READY;
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_NEXT(busy_after_accept_a, clk_i, rst_ni, accept, in_stall_o)
  `ASSERT_ALWAYS(div_nonzero_a, clk_i, rst_ni, (state_q == ST_DIV) |-> !sts_i.den_zero)
  `ASSERT_NEXT(probe_sets_iter_a, clk_i, rst_ni, cmd_o.probe, phase_q == PH_ITER)

endmodule

// ===== rtl/core/bracketed_root_finder.sv =====
// Channel   Direction  Handshake                   Payload
// in        input      in_valid_i / in_stall_o     opcode, bracket ends, target, f value
// out       output     out_valid_o / out_stall_i   kind, x_value
// cfg       input      cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// One transaction is worked on at a time; each input gives exactly one result.
// A start or a value while idle goes straight to the output register, the
// low-end value via the update state, an iteration via update, test, decide, the
// restoring divider (one quotient bit per cycle, 16 bits for Q16.16), step and probe.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled output holds its result while the next input is already taken.
module bracketed_root_finder #(
  parameter int unsigned FRAC_BITS = brf_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                opcode_i,
  input  logic signed [31:0]  bracket_low_i,
  input  logic signed [31:0]  bracket_high_i,
  input  logic signed [31:0]  target_value_i,
  input  logic signed [31:0]  function_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          kind_o,
  output logic signed [31:0]  x_value_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import brf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  brf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  brf_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .bracket_low_i    (bracket_low_i),
    .bracket_high_i   (bracket_high_i),
    .target_value_i   (target_value_i),
    .function_value_i (function_value_i),
    .kind_o           (kind_o),
    .x_value_o        (x_value_o)
  );

endmodule
